[rtl/core/irclt_pkg.sv]
package irclt_pkg;

  // Longest command word that is buffered before the message is dropped.
  localparam int unsigned CMD_MAX_LEN = 7;
  localparam int unsigned NB_CMD      = 10;
  localparam int unsigned LEN_W       = $clog2(CMD_MAX_LEN + 1);
  localparam int unsigned IDX_W       = $clog2(CMD_MAX_LEN);
  localparam int unsigned KW_W        = $clog2(NB_CMD);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_TGT = 2'd1;
  localparam logic [1:0] KIND_MSG = 2'd2;

  // Work handed from the front part to the back part.
  typedef enum logic [1:0] {
    OP_ONE  = 2'd0,
    OP_PAIR = 2'd1,
    OP_CMD  = 2'd2
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [7:0]      data;
    logic            valid;
    logic [1:0]      kind;
    logic            start;
    logic            status;
    logic            last;
    logic [KW_W-1:0] cmd;
  } token_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [1:0] kind;
    logic       start;
    logic       msg_end;
    logic       status;
  } result_t;

  // Keywords are left aligned, first character in the top byte.
  function automatic logic [8*CMD_MAX_LEN-1:0] kw_word(input logic [KW_W-1:0] k);
    logic [8*CMD_MAX_LEN-1:0] w;
    case (k)
      4'd0:    w = {"USER", 24'h0};
      4'd1:    w = {"NICK", 24'h0};
      4'd2:    w = {"PASS", 24'h0};
      4'd3:    w = "PRIVMSG";
      4'd4:    w = {"JOIN", 24'h0};
      4'd5:    w = {"LIST", 24'h0};
      4'd6:    w = {"NAMES", 16'h0};
      4'd7:    w = {"NOTICE", 8'h0};
      4'd8:    w = {"INVITE", 8'h0};
      4'd9:    w = {"QUIT", 24'h0};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [LEN_W-1:0] kw_len(input logic [KW_W-1:0] k);
    logic [LEN_W-1:0] n;
    case (k)
      4'd3:          n = LEN_W'(7);
      4'd6:          n = LEN_W'(5);
      4'd7, 4'd8:    n = LEN_W'(6);
      4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd9: n = LEN_W'(4);
      default:       n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [KW_W-1:0] k,
                                         input logic [IDX_W-1:0] i);
    logic [8*CMD_MAX_LEN-1:0] w;
    w = kw_word(k);
    return w[8*(CMD_MAX_LEN-1-i) +: 8];
  endfunction

endpackage

[rtl/core/irc_command_line_tokenizer_unit.sv]
// Channel   Direction  Handshake              Payload
// input     in         push / full            in_byte_i, is_last_i
// results   out        empty / pop            out_byte_o, byte_valid_o, field_kind_o,
//                                             token_start_o, message_end_o, status_o
//
// A message byte is taken in every cycle while full is low; full rises only when the
// four-entry work queue between the classifier and the result generator is full.
// The result generator issues each character, marker or status result on its own, so
// a recognised command gives as many results as its length (up to seven) and a joining
// comma gives one more; those bursts are what fill the queue and hold off the input.
// Reset clears the parser state, the queue and the result valid flag; nothing is swept.
// The result register holds its transaction while pop is low; new bytes still enter.
module irc_command_line_tokenizer_unit
  import irclt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic [1:0] field_kind_o,
  output logic       token_start_o,
  output logic       message_end_o,
  output logic       status_o
);

  // An input transaction completes whenever push meets a queue with room, whether or
  // not the byte gives any work to the back part.
  logic    accept;
  logic    tok_valid;
  token_t  tok;
  logic    q_valid;
  token_t  q_data;
  logic    q_pop;
  result_t res;

  assign accept = push && !full;

  // Front part: tracks the phase of the message, buffers the command word and
  // turns each byte into at most one work token.
  irclt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .is_last_i   (is_last_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok)
  );

  // Short queue that lets the two halves stall independently.
  irclt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (tok_valid),
    .wr_data_i  (tok),
    .full_o     (full),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_data),
    .rd_ready_i (q_pop)
  );

  // Back part: expands each token into one or more result transactions, the command
  // word being spelt out from the keyword table.
  irclt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (q_data),
    .tok_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign out_byte_o    = res.data;
  assign byte_valid_o  = res.valid;
  assign field_kind_o  = res.kind;
  assign token_start_o = res.start;
  assign message_end_o = res.msg_end;
  assign status_o      = res.status;

endmodule

[rtl/core/irclt_front.sv]
module irclt_front
  import irclt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  output logic       tok_valid_o,
  output token_t     tok_o
);

  typedef enum logic [3:0] {
    PH_CMD  = 4'b0001,
    PH_TGT  = 4'b0010,
    PH_MSG  = 4'b0100,
    PH_DROP = 4'b1000
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             in_word_q, in_word_d;
  logic             comma_q, comma_d;
  logic             seen_q, seen_d;
  logic [7:0]       buf_q [CMD_MAX_LEN];
  logic             buf_we;

  logic             blank, sep;
  logic [LEN_W:0]   eff_len;
  logic             append;
  logic             match;
  logic [KW_W-1:0]  match_idx;
  logic             tok_valid;
  token_t           tok;

  function automatic token_t mk_one(input logic [7:0] b, input logic v,
                                    input logic [1:0] kd, input logic st);
    token_t t;
    t        = '0;
    t.op     = OP_ONE;
    t.data   = b;
    t.valid  = v;
    t.kind   = kd;
    t.start  = st;
    return t;
  endfunction

  assign blank  = (in_byte_i == CH_SPACE) || (in_byte_i == CH_TAB);
  assign sep    = blank || (in_byte_i == CH_COMMA) || (in_byte_i == CH_COLON);
  assign append = !sep;
  assign eff_len = append ? ({1'b0, len_q} + (LEN_W+1)'(1)) : {1'b0, len_q};

  // The word being closed is the buffer plus, when appending, the new byte.
  always_comb begin
    logic       hit;
    logic [7:0] ch;
    match     = 1'b0;
    match_idx = '0;
    for (int k = 0; k < NB_CMD; k++) begin
      hit = ({1'b0, kw_len(KW_W'(k))} == eff_len);
      for (int i = 0; i < CMD_MAX_LEN; i++) begin
        ch = (append && (LEN_W'(i) == len_q)) ? in_byte_i : buf_q[i];
        if ((LEN_W+1)'(i) < eff_len && ch != kw_char(KW_W'(k), IDX_W'(i))) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        match     = 1'b1;
        match_idx = KW_W'(k);
      end
    end
  end

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    in_word_d = in_word_q;
    comma_d   = comma_q;
    seen_d    = seen_q;
    buf_we    = 1'b0;
    tok_valid = 1'b0;
    tok       = '0;

    unique case (phase_q)
      PH_CMD: begin
        if (sep) begin
          if (len_q == '0 && blank) begin
            // Blanks ahead of the command are skipped, even on the final byte.
          end else if (match) begin
            tok_valid = 1'b1;
            tok.op    = OP_CMD;
            tok.cmd   = match_idx;
            phase_d   = (in_byte_i == CH_COLON) ? PH_MSG : PH_TGT;
            in_word_d = 1'b0;
          end else begin
            phase_d = PH_DROP;
          end
        end else if (len_q < LEN_W'(CMD_MAX_LEN)) begin
          buf_we = 1'b1;
          len_d  = len_q + LEN_W'(1);
          if (is_last_i) begin
            if (match) begin
              tok_valid = 1'b1;
              tok.op    = OP_CMD;
              tok.cmd   = match_idx;
              phase_d   = PH_TGT;
            end else begin
              phase_d = PH_DROP;
            end
          end
        end else begin
          phase_d = PH_DROP;
        end
      end
      PH_TGT: begin
        if (in_byte_i == CH_COLON) begin
          phase_d   = PH_MSG;
          in_word_d = 1'b0;
          comma_d   = 1'b0;
        end else if (blank) begin
          in_word_d = 1'b0;
        end else if (in_byte_i == CH_COMMA) begin
          if (seen_q) begin
            comma_d = 1'b1;
          end
          in_word_d = 1'b0;
        end else if (in_word_q) begin
          tok_valid = 1'b1;
          tok       = mk_one(in_byte_i, 1'b1, KIND_TGT, 1'b0);
        end else if (!seen_q) begin
          tok_valid = 1'b1;
          tok       = mk_one(in_byte_i, 1'b1, KIND_TGT, 1'b1);
          seen_d    = 1'b1;
          in_word_d = 1'b1;
        end else if (comma_q) begin
          tok_valid = 1'b1;
          tok       = mk_one(in_byte_i, 1'b1, KIND_TGT, 1'b1);
          tok.op    = OP_PAIR;
          comma_d   = 1'b0;
          in_word_d = 1'b1;
        end else begin
          // A word after a blank without a comma opens the message words.
          phase_d   = PH_MSG;
          comma_d   = 1'b0;
          tok_valid = 1'b1;
          tok       = mk_one(in_byte_i, 1'b1, KIND_MSG, 1'b1);
          in_word_d = 1'b1;
        end
      end
      PH_MSG: begin
        if (blank || in_byte_i == CH_COLON) begin
          in_word_d = 1'b0;
        end else if (in_byte_i == CH_COMMA) begin
          tok_valid = 1'b1;
          tok       = mk_one(in_byte_i, 1'b1, KIND_MSG, 1'b1);
          in_word_d = 1'b0;
        end else begin
          tok_valid = 1'b1;
          tok       = mk_one(in_byte_i, 1'b1, KIND_MSG, !in_word_q);
          in_word_d = 1'b1;
        end
      end
      PH_DROP: begin
      end
      default: begin
        phase_d = PH_CMD;
      end
    endcase

    if (is_last_i) begin
      if (phase_d == PH_DROP) begin
        tok_valid  = 1'b1;
        tok        = mk_one(8'h00, 1'b0, KIND_CMD, 1'b0);
        tok.status = 1'b1;
      end else if (!tok_valid) begin
        tok_valid = 1'b1;
        tok       = mk_one(8'h00, 1'b0, (phase_d == PH_MSG) ? KIND_MSG : KIND_TGT, 1'b0);
      end
      tok.last  = 1'b1;
      phase_d   = PH_CMD;
      len_d     = '0;
      in_word_d = 1'b0;
      comma_d   = 1'b0;
      seen_d    = 1'b0;
    end
  end

  assign tok_valid_o = accept_i && tok_valid;
  assign tok_o       = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_CMD;
      len_q     <= '0;
      in_word_q <= 1'b0;
      comma_q   <= 1'b0;
      seen_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      in_word_q <= in_word_d;
      comma_q   <= comma_d;
      seen_q    <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && buf_we) begin
      buf_q[len_q[IDX_W-1:0]] <= in_byte_i;
    end
  end

endmodule

[rtl/core/irclt_queue.sv]
module irclt_queue
  import irclt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_valid_i,
  input  token_t wr_data_i,
  output logic   full_o,
  output logic   rd_valid_o,
  output token_t rd_data_o,
  input  logic   rd_ready_i
);

  token_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_ready_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[rtl/core/irclt_back.sv]
module irclt_back
  import irclt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    tok_valid_i,
  input  token_t  tok_i,
  output logic    tok_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t res_o
);

  token_t           cur_q;
  logic             cur_valid_q;
  logic [IDX_W-1:0] idx_q;
  result_t          out_q;
  logic             out_valid_q;

  result_t          res;
  logic             fin;
  logic             advance, emit, cur_free;

  // Expand the current token into the result for the present index.
  always_comb begin
    res        = '0;
    fin        = 1'b1;
    res.data   = cur_q.data;
    res.valid  = cur_q.valid;
    res.kind   = cur_q.kind;
    res.start  = cur_q.start;
    res.status = cur_q.status;
    res.msg_end = cur_q.last;
    unique case (cur_q.op)
      OP_PAIR: begin
        if (idx_q == '0) begin
          res.data    = CH_COMMA;
          res.start   = 1'b0;
          res.msg_end = 1'b0;
          fin         = 1'b0;
        end
      end
      OP_CMD: begin
        fin = ((LEN_W+1)'(idx_q) + (LEN_W+1)'(1)) == (LEN_W+1)'(kw_len(cur_q.cmd));
        res.data    = kw_char(cur_q.cmd, idx_q);
        res.valid   = 1'b1;
        res.kind    = KIND_CMD;
        res.start   = (idx_q == '0);
        res.status  = 1'b0;
        res.msg_end = cur_q.last && fin;
      end
      default: begin
      end
    endcase
  end

  assign advance   = !out_valid_q || pop_i;
  assign emit      = cur_valid_q && advance;
  assign cur_free  = !cur_valid_q || (emit && fin);
  assign tok_pop_o = cur_free && tok_valid_i;
  assign empty_o   = !out_valid_q;
  assign res_o     = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (tok_pop_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= '0;
      end else begin
        if (emit && fin) begin
          cur_valid_q <= 1'b0;
        end
        if (emit) begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_pop_o) begin
      cur_q <= tok_i;
    end
    if (emit) begin
      out_q <= res;
    end
  end

endmodule
